>>> hdl/akcd_pkg.sv
// ----------------------------------------------------------------------------
// akcd_pkg
// Types and fixed codes shared by the analog key channel discovery block.
// ----------------------------------------------------------------------------
package akcd_pkg;

    localparam int KIND_W   = 2;
    localparam int CH_W     = 5;
    localparam int SAMPLE_W = 12;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 16;

    // input kinds
    localparam logic [1:0] KIND_SAMPLE = 2'd0;
    localparam logic [1:0] KIND_TICK   = 2'd1;
    localparam logic [1:0] KIND_REARM  = 2'd2;

    // result events
    localparam logic [1:0] EV_BASELINE = 2'd0;
    localparam logic [1:0] EV_FOUND    = 2'd1;
    localparam logic [1:0] EV_REARM    = 2'd2;
    localparam logic [1:0] EV_RELEASE  = 2'd3;

    // register indexes
    localparam logic [2:0] REG_PRESS_TH   = 3'd0;
    localparam logic [2:0] REG_RELEASE_TH = 3'd1;
    localparam logic [2:0] REG_WINDOW     = 3'd2;
    localparam logic [2:0] REG_HOLD       = 3'd3;
    localparam logic [2:0] REG_RELEASE_T  = 3'd4;
    localparam logic [2:0] REG_KEY_TOTAL  = 3'd5;

    localparam logic [19:0] SCAN_MAX = 20'hFFFFF;

    typedef struct packed {
        logic [1:0]  kind;
        logic [4:0]  channel;
        logic [11:0] sample;
        logic        scan_end;
    } t_item;

    typedef struct packed {
        logic [1:0]  event_res;
        logic [4:0]  key_number;
        logic [4:0]  found_channel;
        logic [11:0] baseline_min;
        logic [11:0] baseline_max;
        logic        all_done;
    } t_result;

    typedef struct packed {
        logic [11:0] press_threshold;
        logic [11:0] release_threshold;
        logic [15:0] baseline_window_ms;
        logic [15:0] hold_time_ms;
        logic [15:0] release_time_ms;
        logic [5:0]  key_total;
    } t_cfg;

endpackage

>>> hdl/akcd_if.sv
// ----------------------------------------------------------------------------
// akcd_if
// Valid/ready channels: item stream, result stream and register writes.
// ----------------------------------------------------------------------------
interface akcd_item_if;
    import akcd_pkg::*;
    logic  valid;
    logic  ready;
    t_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface akcd_result_if;
    import akcd_pkg::*;
    logic    valid;
    logic    ready;
    t_result data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface akcd_cfg_if;
    import akcd_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_DAT_W-1:0] wdata;
    modport source (output valid, output index, output wdata, input ready);
    modport sink   (input valid, input index, input wdata, output ready);
endinterface

>>> hdl/akcd_ram.sv
// ----------------------------------------------------------------------------
// akcd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module akcd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

>>> hdl/akcd_front.sv
// ----------------------------------------------------------------------------
// akcd_front
// Accepts items, drops kinds that never act, and pushes the rest into a
// short queue toward the back end.
// ----------------------------------------------------------------------------
module akcd_front #(
    parameter int DEPTH = 4
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    akcd_item_if.sink              in_if,
    input  logic                   i_pop,
    output logic                   o_avail,
    output akcd_pkg::t_item        o_head
);
    import akcd_pkg::*;

    localparam int AW = $clog2(DEPTH);

    t_item         r_q [DEPTH];
    logic [AW-1:0] r_wp, r_rp;
    logic [AW:0]   r_cnt;
    logic          push;

    // unknown kind is classified away here
    assign in_if.ready = (r_cnt != AW'(0) + (AW+1)'(DEPTH)) ;
    assign push = in_if.valid && in_if.ready && (in_if.data.kind != 2'd3);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_q[r_wp] <= in_if.data;
                r_wp      <= r_wp + AW'(1);
            end
            if (i_pop) begin
                r_rp <= r_rp + AW'(1);
            end
            r_cnt <= r_cnt + (AW+1)'(push) - (AW+1)'(i_pop);
        end
    end

    assign o_avail = (r_cnt != '0);
    assign o_head  = r_q[r_rp];
endmodule

>>> hdl/akcd_back.sv
// ----------------------------------------------------------------------------
// akcd_back
// Sequencer that runs the baseline, press and release phases for one
// queued item at a time, with a per-channel division pass at baseline end.
// ----------------------------------------------------------------------------
module akcd_back #(
    parameter int NUM_CHANNELS = 32,
    parameter int MAX_KEYS     = 32,
    parameter int ADC_BITS     = 12
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  akcd_pkg::t_cfg    i_cfg,
    input  logic              i_avail,
    input  akcd_pkg::t_item   i_head,
    output logic              o_pop,
    akcd_result_if.source     out_if
);
    import akcd_pkg::*;

    localparam int CW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam logic [31:0] ADC_MAX = 32'((64'd1 << ADC_BITS) - 64'd1);

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_READ  = 8'b0000_0010,
        S_EXEC  = 8'b0000_0100,
        S_CLR   = 8'b0000_1000,
        S_DRD   = 8'b0001_0000,
        S_DIV   = 8'b0010_0000,
        S_DWR   = 8'b0100_0000,
        S_OUT   = 8'b1000_0000
    } t_state;

    localparam logic [1:0] PH_BASE = 2'd0, PH_PRESS = 2'd1, PH_REL = 2'd2, PH_DONE = 2'd3;

    t_state       r_state;
    t_item        r_it;
    logic [1:0]   r_phase;
    logic [31:0]  r_now;
    logic [19:0]  r_scan;
    logic         r_bvalid;
    logic [4:0]   r_bch;
    logic [12:0]  r_bdelta;
    logic         r_cvalid;
    logic [4:0]   r_cch;
    logic [31:0]  r_cstart;
    logic         r_rvalid;
    logic [31:0]  r_rsince;
    logic [5:0]   r_key;
    logic [CW-1:0] r_idx;
    logic [CW:0]  r_clr;
    logic         r_cleared;
    logic [11:0]  r_mn, r_mx;
    logic [31:0]  r_rem, r_quo, r_div;
    logic [5:0]   r_bit;
    t_result      r_res;
    logic         r_ovalid;

    // sum memory and baseline memory
    logic          sum_we;
    logic [CW-1:0] sum_wa, sum_ra;
    logic [31:0]   sum_wd, sum_rd;
    logic          bl_we;
    logic [CW-1:0] bl_wa, bl_ra;
    logic [11:0]   bl_wd, bl_rd;

    akcd_ram #(.WIDTH(32), .DEPTH(1 << CW)) u_sum (
        .i_clk(i_clk), .i_we(sum_we), .i_waddr(sum_wa), .i_wdata(sum_wd),
        .i_raddr(sum_ra), .o_rdata(sum_rd));
    akcd_ram #(.WIDTH(12), .DEPTH(1 << CW)) u_bl (
        .i_clk(i_clk), .i_we(bl_we), .i_waddr(bl_wa), .i_wdata(bl_wd),
        .i_raddr(bl_ra), .o_rdata(bl_rd));

    logic          ch_ok;
    logic [CW-1:0] ch_i;
    logic [32:0]   sum_t;
    logic [13:0]   delta;
    logic [5:0]    total;
    logic [32:0]   trial;
    logic [11:0]   bsat;

    assign ch_ok = (32'(r_it.channel) < 32'(NUM_CHANNELS));
    assign ch_i  = CW'(r_it.channel);
    assign sum_t = {1'b0, sum_rd} + 33'(r_it.sample);
    assign delta = {2'b00, r_it.sample} - {2'b00, bl_rd};
    assign trial = {r_rem[31:0], r_quo[31]} - {1'b0, r_div};
    assign bsat  = (r_quo > ADC_MAX) ? 12'(ADC_MAX) : r_quo[11:0];

    always_comb begin
        total = i_cfg.key_total;
        if (total == 6'd0) total = 6'd1;
        if (32'(total) > 32'(MAX_KEYS)) total = 6'(MAX_KEYS);
    end

    // the head beat's channel is read while it is popped
    assign sum_ra = (r_state == S_IDLE) ? CW'(i_head.channel) : r_idx;
    assign bl_ra  = sum_ra;
    assign o_pop  = (r_state == S_IDLE) && i_avail && r_cleared;
    assign out_if.valid = r_ovalid;
    assign out_if.data  = r_res;

    always_comb begin
        sum_we = 1'b0; sum_wa = r_idx; sum_wd = '0;
        bl_we  = 1'b0; bl_wa  = r_idx; bl_wd  = bsat;
        if (r_state == S_CLR) begin
            sum_we = 1'b1; sum_wa = r_clr[CW-1:0];
        end else if (r_state == S_EXEC && r_phase == PH_BASE &&
                     r_it.kind == KIND_SAMPLE && ch_ok) begin
            sum_we = 1'b1; sum_wa = ch_i;
            sum_wd = sum_t[32] ? 32'hFFFF_FFFF : sum_t[31:0];
        end else if (r_state == S_DWR) begin
            bl_we = 1'b1;
        end
    end

    task automatic emit(input logic [1:0] ev, input logic [4:0] k, input logic [4:0] c,
                        input logic [11:0] mn, input logic [11:0] mx, input logic d);
        r_res    <= '{ev, k, c, mn, mx, d};
        r_ovalid <= 1'b1;
        r_state  <= S_OUT;
    endtask

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR; r_phase <= PH_BASE; r_now <= '0; r_scan <= '0;
            r_bvalid <= 1'b0; r_bch <= '0; r_bdelta <= '0; r_cvalid <= 1'b0;
            r_cch <= '0; r_cstart <= '0; r_rvalid <= 1'b0; r_rsince <= '0;
            r_key <= '0; r_idx <= '0; r_clr <= '0; r_cleared <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            case (r_state)
                // clearing pass over the sum memory after reset
                S_CLR: begin
                    r_clr <= r_clr + 1'b1;
                    if (32'(r_clr) == 32'(NUM_CHANNELS - 1)) begin
                        r_cleared <= 1'b1; r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (o_pop) begin
                        r_it <= i_head; r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    r_state <= S_IDLE;
                    if (r_it.kind == KIND_TICK) begin
                        r_now <= r_now + 32'd1;
                        if (r_phase == PH_BASE &&
                            r_now + 32'd1 >= 32'(i_cfg.baseline_window_ms)) begin
                            r_idx <= '0; r_mn <= 12'(ADC_MAX); r_mx <= '0;
                            r_state <= S_READ;
                        end
                    end else if (r_it.kind == KIND_REARM) begin
                        if (r_phase == PH_PRESS) begin
                            r_cvalid <= 1'b0; r_bvalid <= 1'b0; r_bch <= '0; r_bdelta <= '0;
                            emit(EV_REARM, r_key[4:0], 5'd0, 12'd0, 12'd0, 1'b0);
                        end
                    end else if (r_phase == PH_BASE) begin
                        if (r_it.scan_end) begin
                            if (r_scan < SCAN_MAX) r_scan <= r_scan + 20'd1;
                            if (r_scan >= SCAN_MAX - 20'd1) begin
                                r_idx <= '0; r_mn <= 12'(ADC_MAX); r_mx <= '0;
                                r_state <= S_READ;
                            end
                        end
                    end else if (r_phase == PH_PRESS) begin
                        logic       nbv;
                        logic [4:0] nbc;
                        nbv = r_bvalid; nbc = r_bch;
                        if (ch_ok && !delta[13] && delta[12:0] > {1'b0, i_cfg.press_threshold}
                            && (!r_bvalid || delta[12:0] > r_bdelta ||
                                (delta[12:0] == r_bdelta && r_it.channel < r_bch))) begin
                            nbv = 1'b1; nbc = r_it.channel;
                            if (!r_it.scan_end) begin
                                r_bvalid <= 1'b1; r_bdelta <= delta[12:0];
                                r_bch <= r_it.channel;
                            end
                        end
                        if (r_it.scan_end) begin
                            r_bvalid <= 1'b0; r_bch <= '0; r_bdelta <= '0;
                            if (!nbv) begin
                                r_cvalid <= 1'b0;
                            end else if (!r_cvalid || nbc != r_cch) begin
                                r_cvalid <= 1'b1; r_cch <= nbc; r_cstart <= r_now;
                            end else if (r_now - r_cstart >= 32'(i_cfg.hold_time_ms)) begin
                                r_phase <= PH_REL; r_rvalid <= 1'b0; r_rsince <= '0;
                                emit(EV_FOUND, r_key[4:0], r_cch, 12'd0, 12'd0, 1'b0);
                            end
                        end
                    end else if (r_phase == PH_REL) begin
                        if (ch_ok && r_it.channel == r_cch) begin
                            if (delta[13] || delta[12:0] < {1'b0, i_cfg.release_threshold}) begin
                                logic [31:0] since;
                                since = r_rvalid ? r_rsince : r_now;
                                if (r_now - since >= 32'(i_cfg.release_time_ms)) begin
                                    r_key <= r_key + 6'd1;
                                    r_phase <= (r_key + 6'd1 >= total) ? PH_DONE : PH_PRESS;
                                    r_cvalid <= 1'b0; r_rvalid <= 1'b0;
                                    r_bvalid <= 1'b0; r_bch <= '0; r_bdelta <= '0;
                                    emit(EV_RELEASE, r_key[4:0], r_cch, 12'd0, 12'd0,
                                         r_key + 6'd1 >= total);
                                end else begin
                                    r_rvalid <= 1'b1; r_rsince <= since;
                                end
                            end else begin
                                r_rvalid <= 1'b0;
                            end
                        end
                    end
                end
                // division pass: one channel at a time, one quotient bit a cycle
                S_READ: r_state <= S_DRD;
                S_DRD: begin
                    r_quo <= sum_rd; r_rem <= '0; r_bit <= 6'd32;
                    r_div <= (r_scan == '0) ? 32'd1 : 32'(r_scan);
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (!trial[32]) r_rem <= trial[31:0];
                    else            r_rem <= {r_rem[30:0], r_quo[31]};
                    r_quo <= {r_quo[30:0], !trial[32]};
                    r_bit <= r_bit - 6'd1;
                    if (r_bit == 6'd1) r_state <= S_DWR;
                end
                S_DWR: begin
                    logic [11:0] mn, mx;
                    mn = (bsat < r_mn) ? bsat : r_mn;
                    mx = (bsat > r_mx) ? bsat : r_mx;
                    r_mn <= mn; r_mx <= mx;
                    if (32'(r_idx) == 32'(NUM_CHANNELS - 1)) begin
                        r_phase <= PH_PRESS; r_cvalid <= 1'b0;
                        r_bvalid <= 1'b0; r_bch <= '0; r_bdelta <= '0;
                        emit(EV_BASELINE, 5'd0, 5'd0, mn, mx, 1'b0);
                    end else begin
                        r_idx <= r_idx + 1'b1; r_state <= S_READ;
                    end
                end
                S_OUT: begin
                    if (out_if.ready) begin
                        r_ovalid <= 1'b0; r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

>>> hdl/analog_key_channel_discovery_core.sv
// ----------------------------------------------------------------------------
// analog_key_channel_discovery_core
// Learns which analog scan channel belongs to each matrix key.
// ----------------------------------------------------------------------------
// After reset the block clears its channel sum memory, one channel a cycle,
// before it takes items from its queue. Items enter a four-beat queue at
// one per cycle while it has room; the back end then takes one item at a
// time, popping it only while idle, and acts on it before it pops the next.
// The baseline end runs a bit-serial division for every channel, one channel
// after another, and a result beat holds the back end until it is taken.
module analog_key_channel_discovery_core #(
    parameter int NUM_CHANNELS = 32,
    parameter int MAX_KEYS     = 32,
    parameter int ADC_BITS     = 12
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    akcd_item_if.sink     in_if,
    akcd_result_if.source out_if,
    akcd_cfg_if.sink      cfg_if
);
    import akcd_pkg::*;

    t_cfg  r_cfg;
    logic  pop, avail;
    t_item head;

    // register writes
    assign cfg_if.ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{12'd800, 12'd200, 16'd500, 16'd50, 16'd30, 6'd32};
        end else if (cfg_if.valid) begin
            case (cfg_if.index)
                REG_PRESS_TH:   r_cfg.press_threshold    <= cfg_if.wdata[11:0];
                REG_RELEASE_TH: r_cfg.release_threshold  <= cfg_if.wdata[11:0];
                REG_WINDOW:     r_cfg.baseline_window_ms <= cfg_if.wdata;
                REG_HOLD:       r_cfg.hold_time_ms       <= cfg_if.wdata;
                REG_RELEASE_T:  r_cfg.release_time_ms    <= cfg_if.wdata;
                REG_KEY_TOTAL:  r_cfg.key_total          <= cfg_if.wdata[5:0];
                default: ;
            endcase
        end
    end

    akcd_front #(.DEPTH(4)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .in_if(in_if),
        .i_pop(pop), .o_avail(avail), .o_head(head));

    akcd_back #(.NUM_CHANNELS(NUM_CHANNELS), .MAX_KEYS(MAX_KEYS), .ADC_BITS(ADC_BITS)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg(r_cfg), .i_avail(avail),
        .i_head(head), .o_pop(pop), .out_if(out_if));
endmodule

>>> test/analog_key_channel_discovery_core_tb.sv
// ----------------------------------------------------------------------------
// analog_key_channel_discovery_core_tb
// Drives ADC samples, ticks and re-arm requests into the discovery core and
// checks every result beat against a cycle-free model of the key discovery.
// A short stimulus table covers the baseline, ties, a press and a release.
// Random presses and releases then walk the block until all keys are found.
// Register writes are made only while the block is idle.
// ----------------------------------------------------------------------------
module analog_key_channel_discovery_core_tb;
    import akcd_pkg::*;

    localparam int          NCH        = 32;
    localparam int          NKEYS      = 32;
    localparam int          IDLE_LIMIT = 20000;
    localparam int          SETTLE     = 40;
    localparam logic [1:0]  ST_BASE    = 2'd0;
    localparam logic [1:0]  ST_PRESS   = 2'd1;
    localparam logic [1:0]  ST_REL     = 2'd2;
    localparam logic [1:0]  ST_DONE    = 2'd3;
    localparam logic [1:0]  KIND_BAD   = 2'd3;

    logic i_clk;
    logic i_rst_n;

    akcd_item_if   item_ch ();
    akcd_result_if res_ch ();
    akcd_cfg_if    cfg_ch ();

    analog_key_channel_discovery_core u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .in_if   (item_ch),
        .out_if  (res_ch),
        .cfg_if  (cfg_ch)
    );

    // model state of the discovery
    t_cfg        cur_cfg;
    logic [1:0]  m_phase;
    logic [31:0] m_now;
    logic [31:0] m_sum [NCH];
    logic [19:0] m_scans;
    logic [11:0] m_base [NCH];
    logic [4:0]  m_best_ch;
    logic        m_best_v;
    logic [12:0] m_best_d;
    logic [4:0]  m_cand_ch;
    logic        m_cand_v;
    logic [31:0] m_cand_t;
    logic [31:0] m_rel_t;
    logic        m_rel_v;
    logic [5:0]  m_key;

    t_result event_q [$];
    int      errors;
    int      n_items;
    int      n_results;
    int      n_writes;
    int      burst_left;
    int      idle_cycles;
    bit      hold_req;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    task automatic report(input string what, input int want, input int got);
        $display("mismatch %s: expected %0d got %0d", what, want, got);
        errors++;
    endtask

    function automatic logic [11:0] clamp12(input int v);
        if (v < 0) return 12'd0;
        if (v > 4095) return 12'hFFF;
        return v[11:0];
    endfunction

    function automatic t_item mk(input logic [1:0] k, input int ch, input int s,
                                 input bit e);
        t_item it;
        it.kind     = k;
        it.channel  = ch[4:0];
        it.sample   = clamp12(s);
        it.scan_end = e;
        return it;
    endfunction

    function automatic void clear_best();
        m_best_v  = 1'b0;
        m_best_ch = '0;
        m_best_d  = '0;
    endfunction

    function automatic void model_reset();
        cur_cfg = '{12'd800, 12'd200, 16'd500, 16'd50, 16'd30, 6'd32};
        m_phase = ST_BASE;
        m_now   = '0;
        m_scans = '0;
        for (int k = 0; k < NCH; k++) begin
            m_sum[k]  = '0;
            m_base[k] = '0;
        end
        clear_best();
        m_cand_ch = '0;
        m_cand_v  = 1'b0;
        m_cand_t  = '0;
        m_rel_t   = '0;
        m_rel_v   = 1'b0;
        m_key     = '0;
    endfunction

    // per-channel averages, reported as min and max
    function automatic t_result close_baseline();
        t_result     r;
        logic [31:0] cnt;
        logic [31:0] b;
        logic [11:0] mn;
        logic [11:0] mx;
        cnt = (m_scans != 0) ? {12'd0, m_scans} : 32'd1;
        mn  = 12'hFFF;
        mx  = 12'd0;
        for (int k = 0; k < NCH; k++) begin
            b = m_sum[k] / cnt;
            if (b > 32'd4095) b = 32'd4095;
            m_base[k] = b[11:0];
            if (b[11:0] < mn) mn = b[11:0];
            if (b[11:0] > mx) mx = b[11:0];
        end
        m_phase  = ST_PRESS;
        clear_best();
        m_cand_v = 1'b0;
        r = '{EV_BASELINE, 5'd0, 5'd0, mn, mx, 1'b0};
        return r;
    endfunction

    // advance the discovery by one item; returns 1 when an event comes out
    function automatic bit predict_event(input t_item it, output t_result r);
        int          d;
        logic [32:0] t;
        logic [6:0]  total;
        logic [5:0]  k;
        bit          done;
        r = '0;
        if (it.kind == KIND_TICK) begin
            m_now = m_now + 32'd1;
            if (m_phase == ST_BASE && m_now >= {16'd0, cur_cfg.baseline_window_ms}) begin
                r = close_baseline();
                return 1;
            end
            return 0;
        end
        if (it.kind == KIND_REARM) begin
            if (m_phase != ST_PRESS) return 0;
            m_cand_v = 1'b0;
            clear_best();
            r = '{EV_REARM, m_key[4:0], 5'd0, 12'd0, 12'd0, 1'b0};
            return 1;
        end
        if (it.kind != KIND_SAMPLE) return 0;
        d = int'(it.sample) - int'(m_base[it.channel]);
        case (m_phase)
            ST_BASE: begin
                t = {1'b0, m_sum[it.channel]} + {21'd0, it.sample};
                m_sum[it.channel] = t[32] ? 32'hFFFF_FFFF : t[31:0];
                if (it.scan_end) begin
                    if (m_scans < SCAN_MAX) m_scans = m_scans + 20'd1;
                    if (m_scans >= SCAN_MAX) begin
                        r = close_baseline();
                        return 1;
                    end
                end
                return 0;
            end
            ST_PRESS: begin
                if (d > int'(cur_cfg.press_threshold)) begin
                    if (!m_best_v || d[12:0] > m_best_d ||
                        (d[12:0] == m_best_d && it.channel < m_best_ch)) begin
                        m_best_v  = 1'b1;
                        m_best_d  = d[12:0];
                        m_best_ch = it.channel;
                    end
                end
                if (!it.scan_end) return 0;
                if (!m_best_v) begin
                    m_cand_v = 1'b0;
                end else if (!m_cand_v || m_best_ch != m_cand_ch) begin
                    m_cand_v  = 1'b1;
                    m_cand_ch = m_best_ch;
                    m_cand_t  = m_now;
                end else if (m_now - m_cand_t >= {16'd0, cur_cfg.hold_time_ms}) begin
                    m_phase = ST_REL;
                    m_rel_v = 1'b0;
                    m_rel_t = '0;
                    clear_best();
                    r = '{EV_FOUND, m_key[4:0], m_cand_ch, 12'd0, 12'd0, 1'b0};
                    return 1;
                end
                clear_best();
                return 0;
            end
            ST_REL: begin
                total = {1'b0, cur_cfg.key_total};
                if (total < 7'd1) total = 7'd1;
                if (total > 7'(NKEYS)) total = 7'(NKEYS);
                if (it.channel != m_cand_ch) return 0;
                if (d < int'(cur_cfg.release_threshold)) begin
                    if (!m_rel_v) begin
                        m_rel_v = 1'b1;
                        m_rel_t = m_now;
                    end
                    if (m_now - m_rel_t >= {16'd0, cur_cfg.release_time_ms}) begin
                        k       = m_key;
                        done    = ({1'b0, k} + 7'd1 >= total);
                        m_key   = k + 6'd1;
                        m_phase = done ? ST_DONE : ST_PRESS;
                        m_cand_v = 1'b0;
                        m_rel_v  = 1'b0;
                        clear_best();
                        r = '{EV_RELEASE, k[4:0], m_cand_ch, 12'd0, 12'd0, done};
                        return 1;
                    end
                end else begin
                    m_rel_v = 1'b0;
                end
                return 0;
            end
            default: return 0;
        endcase
    endfunction

    // sender: bursts of beats with random gaps
    task automatic push(input t_item it, output bit has, output t_result r);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            repeat (gap) begin
                @(negedge i_clk);
                item_ch.valid <= 1'b0;
            end
            burst_left = $urandom_range(1, 24);
        end
        @(negedge i_clk);
        item_ch.valid <= 1'b1;
        item_ch.data  <= it;
        do @(posedge i_clk); while (!item_ch.ready);
        has = predict_event(it, r);
        if (has) event_q.push_back(r);
        n_items++;
        burst_left--;
        if (burst_left == 0) begin
            @(negedge i_clk);
            item_ch.valid <= 1'b0;
        end
    endtask

    task automatic send(input t_item it);
        bit      has;
        t_result r;
        push(it, has, r);
    endtask

    task automatic wait_idle();
        if (burst_left != 0) begin
            @(negedge i_clk);
            item_ch.valid <= 1'b0;
            burst_left = 0;
        end
        while (event_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input int v);
        wait_idle();
        @(negedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.wdata <= v[15:0];
        do @(posedge i_clk); while (!cfg_ch.ready);
        case (idx)
            REG_PRESS_TH:   cur_cfg.press_threshold    = v[11:0];
            REG_RELEASE_TH: cur_cfg.release_threshold  = v[11:0];
            REG_WINDOW:     cur_cfg.baseline_window_ms = v[15:0];
            REG_HOLD:       cur_cfg.hold_time_ms       = v[15:0];
            REG_RELEASE_T:  cur_cfg.release_time_ms    = v[15:0];
            REG_KEY_TOTAL:  cur_cfg.key_total          = v[5:0];
            default: ;
        endcase
        n_writes++;
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // one random register change, extremes included
    task automatic shuffle_cfg();
        int pick;
        pick = $urandom_range(0, 5);
        case (pick)
            0: write_reg(REG_PRESS_TH, ($urandom_range(0, 7) == 0) ? 0 :
                         ($urandom_range(0, 9) == 0) ? 4095 : $urandom_range(100, 1500));
            1: write_reg(REG_RELEASE_TH, ($urandom_range(0, 7) == 0) ? 0 :
                         ($urandom_range(0, 7) == 0) ? 4095 : $urandom_range(50, 600));
            2: write_reg(REG_WINDOW, ($urandom_range(0, 1) == 0) ? 65535 : $urandom_range(1, 100));
            3: write_reg(REG_HOLD, ($urandom_range(0, 15) == 0) ? 65535 : $urandom_range(0, 6));
            4: write_reg(REG_RELEASE_T, ($urandom_range(0, 15) == 0) ? 65535 :
                         $urandom_range(0, 5));
            default: write_reg(REG_KEY_TOTAL, ($urandom_range(0, 1) == 0) ? 63 : 32);
        endcase
    endtask

    function automatic t_item noise_sample(input bit e);
        int ch;
        ch = $urandom_range(0, NCH - 1);
        if ($urandom_range(0, 7) == 0) return mk(KIND_SAMPLE, ch, $urandom_range(0, 4095), e);
        return mk(KIND_SAMPLE, ch, int'(m_base[ch]) + $urandom_range(0, 250), e);
    endfunction

    task automatic send_ticks(input int hi);
        repeat ($urandom_range(0, hi)) send(mk(KIND_TICK, 0, 0, 0));
    endtask

    // one partial scan with a pressed channel and maybe an equal-delta rival
    task automatic press_scan(input int c);
        int  tgt;
        int  c2;
        int  v2;
        bit  tie;
        bit  ended;
        repeat ($urandom_range(0, 3)) send(noise_sample(0));
        tgt = int'(m_base[c]) + int'(cur_cfg.press_threshold) + 1 + $urandom_range(0, 400);
        c2  = $urandom_range(0, NCH - 1);
        v2  = int'(m_base[c2]) + tgt - int'(m_base[c]);
        tie = ($urandom_range(0, 4) == 0) && v2 <= 4095 && tgt <= 4095;
        ended = !tie && $urandom_range(0, 1);
        send(mk(KIND_SAMPLE, c, tgt, ended));
        if (tie) send(mk(KIND_SAMPLE, c2, v2, 0));
        if (!ended) send(noise_sample(1));
        case ($urandom_range(0, 11))
            0: send(mk(KIND_REARM, $urandom_range(0, 31), $urandom_range(0, 4095), 0));
            1: send(mk(KIND_BAD, $urandom_range(0, 31), $urandom_range(0, 4095), 1));
            default: ;
        endcase
        send_ticks(3);
    endtask

    task automatic release_step();
        int lvl;
        if ($urandom_range(0, 1) == 0) send(noise_sample($urandom_range(0, 1)));
        if ($urandom_range(0, 5) == 0)
            lvl = int'(m_base[m_cand_ch]) + int'(cur_cfg.release_threshold) + $urandom_range(0, 300);
        else
            lvl = int'(m_base[m_cand_ch]) + int'(cur_cfg.release_threshold) - 1 -
                  $urandom_range(0, 300);
        send(mk(KIND_SAMPLE, m_cand_ch, lvl, $urandom_range(0, 1)));
        send_ticks(2);
    endtask

    typedef struct {
        t_item   it;
        bit      chk;
        t_result want;
    } t_row;

    // receiver: changing stall pattern plus a long hold-off whenever one is requested
    initial begin
        int mode;
        int cyc;
        res_ch.ready = 1'b0;
        mode = 0;
        cyc  = 0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                res_ch.ready <= 1'b0;
                repeat (300) @(negedge i_clk);
                hold_req = 1'b0;
            end
            cyc++;
            if (cyc % 64 == 0) mode = $urandom_range(0, 3);
            case (mode)
                0: res_ch.ready <= 1'b1;
                1: res_ch.ready <= ($urandom_range(0, 3) != 0);
                2: res_ch.ready <= $urandom_range(0, 1);
                default: res_ch.ready <= (cyc % 4 == 0);
            endcase
        end
    end

    // result check and watchdog
    always @(posedge i_clk) begin
        t_result want;
        t_result got;
        if (res_ch.valid && res_ch.ready) begin
            got = res_ch.data;
            n_results++;
            if (event_q.size() == 0) begin
                $display("unexpected result beat, event %0d", got.event_res);
                errors++;
            end else begin
                want = event_q.pop_front();
                if (got.event_res != want.event_res)
                    report("event", want.event_res, got.event_res);
                if (got.key_number != want.key_number)
                    report("key_number", want.key_number, got.key_number);
                if (got.found_channel != want.found_channel)
                    report("found_channel", want.found_channel, got.found_channel);
                if (got.baseline_min != want.baseline_min)
                    report("baseline_min", want.baseline_min, got.baseline_min);
                if (got.baseline_max != want.baseline_max)
                    report("baseline_max", want.baseline_max, got.baseline_max);
                if (got.all_done != want.all_done)
                    report("all_done", want.all_done, got.all_done);
            end
        end
        if ((item_ch.valid && item_ch.ready) || (res_ch.valid && res_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no beat for %0d cycles", IDLE_LIMIT);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // stimulus
    initial begin
        t_row    rows [$];
        t_result r;
        bit      has;
        int      c;
        int      tries;
        item_ch.valid = 1'b0;
        item_ch.data  = '0;
        cfg_ch.valid  = 1'b0;
        cfg_ch.index  = '0;
        cfg_ch.wdata  = '0;
        hold_req      = 1'b0;
        errors        = 0;
        n_items       = 0;
        n_results     = 0;
        n_writes      = 0;
        burst_left    = 0;
        idle_cycles   = 0;
        model_reset();
        i_rst_n = 1'b0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        write_reg(REG_PRESS_TH, 800);
        write_reg(REG_RELEASE_TH, 200);
        write_reg(REG_WINDOW, 2);
        write_reg(REG_HOLD, 0);
        write_reg(REG_RELEASE_T, 0);
        write_reg(REG_KEY_TOTAL, 32);

        // directed: baseline, re-arm, tie, press, release, dropped candidate
        rows.push_back('{mk(KIND_BAD, 31, 4095, 1), 1'b0, '0});
        rows.push_back('{mk(KIND_REARM, 0, 0, 0), 1'b0, '0});
        rows.push_back('{mk(KIND_SAMPLE, 0, 4095, 0), 1'b0, '0});
        rows.push_back('{mk(KIND_SAMPLE, 1, 0, 0), 1'b0, '0});
        rows.push_back('{mk(KIND_SAMPLE, 31, 4095, 1), 1'b0, '0});
        rows.push_back('{mk(KIND_SAMPLE, 5, 2000, 1), 1'b0, '0});
        rows.push_back('{mk(KIND_TICK, 0, 0, 0), 1'b0, '0});
        rows.push_back('{mk(KIND_TICK, 0, 0, 0), 1'b1,
                         '{EV_BASELINE, 5'd0, 5'd0, 12'd0, 12'd2047, 1'b0}});
        rows.push_back('{mk(KIND_REARM, 0, 0, 0), 1'b1,
                         '{EV_REARM, 5'd0, 5'd0, 12'd0, 12'd0, 1'b0}});
        rows.push_back('{mk(KIND_BAD, 0, 0, 0), 1'b0, '0});
        rows.push_back('{mk(KIND_SAMPLE, 4, 1000, 0), 1'b0, '0});
        rows.push_back('{mk(KIND_SAMPLE, 3, 1000, 1), 1'b0, '0});
        rows.push_back('{mk(KIND_SAMPLE, 4, 4095, 0), 1'b0, '0});
        rows.push_back('{mk(KIND_SAMPLE, 3, 4095, 1), 1'b1,
                         '{EV_FOUND, 5'd0, 5'd3, 12'd0, 12'd0, 1'b0}});
        rows.push_back('{mk(KIND_SAMPLE, 3, 900, 0), 1'b0, '0});
        rows.push_back('{mk(KIND_SAMPLE, 3, 0, 0), 1'b1,
                         '{EV_RELEASE, 5'd0, 5'd3, 12'd0, 12'd0, 1'b0}});
        rows.push_back('{mk(KIND_SAMPLE, 0, 4095, 1), 1'b0, '0});
        rows.push_back('{mk(KIND_TICK, 0, 0, 0), 1'b0, '0});
        rows.push_back('{mk(KIND_SAMPLE, 31, 0, 0), 1'b0, '0});
        rows.push_back('{mk(KIND_SAMPLE, 0, 2000, 1), 1'b0, '0});
        rows.push_back('{mk(KIND_REARM, 0, 0, 0), 1'b1,
                         '{EV_REARM, 5'd1, 5'd0, 12'd0, 12'd0, 1'b0}});
        foreach (rows[i]) begin
            push(rows[i].it, has, r);
            if (rows[i].chk && (!has || r != rows[i].want)) begin
                $display("stimulus table row %0d disagrees with the model", i);
                errors++;
            end
        end
        write_reg(REG_HOLD, 2);
        write_reg(REG_RELEASE_T, 1);

        // random presses and releases until every key is found
        while (m_phase != ST_DONE) begin
            if ($urandom_range(0, 2) == 0) shuffle_cfg();
            if (m_key == 6'd4) begin
                // stall the results while re-arms pile up at the input
                wait_idle();
                hold_req = 1'b1;
                repeat (16) send(mk(KIND_REARM, $urandom_range(0, 31), 0, 0));
                wait_idle();
            end
            if (m_key == 6'd28 && cur_cfg.key_total != 0) write_reg(REG_KEY_TOTAL, 0);
            c = $urandom_range(0, NCH - 1);
            tries = 0;
            while (m_phase == ST_PRESS && tries < 30) begin
                press_scan(c);
                tries++;
            end
            if (m_phase == ST_PRESS) begin
                write_reg(REG_PRESS_TH, 600);
                write_reg(REG_HOLD, $urandom_range(0, 3));
                continue;
            end
            tries = 0;
            while (m_phase == ST_REL && tries < 40) begin
                release_step();
                tries++;
            end
            if (m_phase == ST_REL) begin
                write_reg(REG_RELEASE_TH, 300);
                write_reg(REG_RELEASE_T, $urandom_range(0, 2));
            end
        end

        // after the last key only ticks count
        repeat (40) send(mk(2'($urandom_range(0, 3)), $urandom_range(0, 31),
                            $urandom_range(0, 4095), $urandom_range(0, 1)));
        wait_idle();
        repeat (100) @(posedge i_clk);

        $display("covered %0d items, %0d results, %0d register writes, %0d keys found",
                 n_items, n_results, n_writes, m_key);
        if (errors == 0 && event_q.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("%0d mismatches, %0d results missing", errors, event_q.size());
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
